### hdl/psp_pkg.sv
// Package for the preemptive stopwatch profiler: command codes, channel entry type.
// No dependencies.
package psp_pkg;
	localparam int unsigned CHANNELS_DEF  = 8;
	localparam int unsigned TICK_BITS_DEF = 32;

	typedef enum logic [2:0] {
		CMD_START     = 3'd0,
		CMD_STOP      = 3'd1,
		CMD_PAUSE     = 3'd2,
		CMD_RESUME    = 3'd3,
		CMD_READ      = 3'd4,
		CMD_CLR_CUM   = 3'd5,
		CMD_CLR_COUNT = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_PREEMPT,
		ST_WRITE
	} state_t;

	// One channel entry as held in the state memory
	typedef struct packed {
		logic [31:0] start_tick;
		logic [31:0] pause_start_tick;
		logic [31:0] paused_total;
		logic [31:0] last_elapsed;
		logic [31:0] last_cpu;
		logic [31:0] min_cpu;
		logic [31:0] max_cpu;
		logic [31:0] min_elapsed;
		logic [31:0] max_elapsed;
		logic [31:0] preempted_total;
		logic [47:0] cumulative_cpu;
		logic [31:0] stop_count;
		logic [47:0] total_stops;
		logic [31:0] last_period;
		logic        measured;
		logic        is_paused;
		logic [2:0]  preempter_index;
		logic        preempter_valid;
	} entry_t;
endpackage

### hdl/psp_mem.sv
// Channel state memory: one write port, one registered read port, valid bits per row.
// Depends on psp_pkg.
module psp_mem #(
	parameter int unsigned CHANNELS = psp_pkg::CHANNELS_DEF,
	parameter int unsigned AW = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [AW-1:0]        raddr,
	output psp_pkg::entry_t      rdata,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  psp_pkg::entry_t      wdata
);
	import psp_pkg::*;

	entry_t              mem [CHANNELS];
	entry_t              rd_q;
	logic                rvld_q;
	logic [CHANNELS-1:0] vld_q;

	// Write the array; rows never written read as the reset entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_q <= vld_q[raddr];
		end
	end

	assign rdata = rvld_q ? rd_q : entry_t'('0);
endmodule

### hdl/preemptive_stopwatch_profiler_unit.sv
// Preemptive stopwatch profiler top level: command sequencer around the channel memory.
// Timing: the strobe is registered from the read state, or, for a stop with a valid preempter,
// which reads and updates the preempter's entry too, from the preempt state after the write state.
// busy covers the read, write and, for such a stop, preempt states; start is ignored while busy.
// Reset clears valid bits, so every channel reads as its reset entry; no clearing pass.
// Result strobe cannot be stalled by the receiver.
// Depends on psp_pkg and psp_mem.
module preemptive_stopwatch_profiler_unit #(
	parameter int unsigned CHANNELS  = psp_pkg::CHANNELS_DEF,
	parameter int unsigned TICK_BITS = psp_pkg::TICK_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [2:0]  channel,
	input  logic [31:0] now_ticks,
	output logic        done,
	output logic [31:0] elapsed_time,
	output logic [31:0] cpu_time,
	output logic [31:0] min_cpu_time,
	output logic [31:0] max_cpu_time,
	output logic [31:0] min_elapsed_time,
	output logic [31:0] max_elapsed_time,
	output logic [31:0] preempted_time,
	output logic [47:0] cumulative_cpu_time,
	output logic [31:0] event_count,
	output logic [47:0] total_event_count,
	output logic [31:0] period_time,
	output logic        measured_once
);
	import psp_pkg::*;

	localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [31:0] TMASK = (TICK_BITS >= 32) ? 32'hFFFF_FFFF
		: 32'((64'd1 << TICK_BITS) - 64'd1);

	state_t      state_q, state_d;
	logic [2:0]  kind_q;
	logic [2:0]  chan_q;
	logic [31:0] now_q;
	logic        oor_q;
	logic [2:0]  cur_idx_q;
	logic        cur_vld_q;
	entry_t      own_q;
	logic [31:0] el_q;
	logic        pre_hit_q;

	logic [AW-1:0] raddr, waddr;
	entry_t        rdata, wdata, upd;
	logic          we;
	logic [31:0]   el_c, cpu_c, t_c;
	logic          cur_paused_c;

	logic [CHANNELS-1:0] paused_q;

	psp_mem #(.CHANNELS(CHANNELS), .AW(AW)) u_mem (
		.clk(clk), .arst_n(arst_n), .raddr(raddr), .rdata(rdata),
		.we(we), .waddr(waddr), .wdata(wdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (start) state_d = ST_READ;
			ST_READ:    state_d = oor_q ? ST_IDLE : ST_WRITE;
			ST_WRITE:   state_d = (kind_q == CMD_STOP && own_q.preempter_valid
				&& 32'(own_q.preempter_index) < CHANNELS) ? ST_PREEMPT : ST_IDLE;
			ST_PREEMPT: state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign cur_paused_c = paused_q[cur_idx_q[AW-1:0]];

	// Compute the update of the addressed entry from its read data
	always_comb begin
		upd   = rdata;
		el_c  = (now_q - rdata.start_tick - rdata.paused_total) & TMASK;
		cpu_c = (el_c - rdata.preempted_total) & TMASK;
		t_c   = (now_q - rdata.pause_start_tick) & TMASK;
		case (kind_q)
			CMD_START: begin
				upd.start_tick = now_q;
				if (cur_vld_q && 32'(cur_idx_q) < CHANNELS && !cur_paused_c) begin
					upd.preempter_index = cur_idx_q;
					upd.preempter_valid = 1'b1;
				end
				upd.preempted_total = '0;
				if (rdata.measured)
					upd.last_period = (now_q - rdata.start_tick) & TMASK;
			end
			CMD_STOP: begin
				upd.last_elapsed = el_c;
				// own preempter is self: its preempted total grows first
				if (rdata.preempter_valid && rdata.preempter_index == chan_q)
					upd.preempted_total = (rdata.preempted_total + el_c) & TMASK;
				cpu_c = (el_c - upd.preempted_total) & TMASK;
				upd.preempter_index = '0;
				upd.preempter_valid = 1'b0;
				upd.stop_count  = rdata.stop_count + 32'd1;
				upd.total_stops = rdata.total_stops + 48'd1;
				upd.last_cpu = cpu_c;
				upd.cumulative_cpu = rdata.cumulative_cpu + 48'(cpu_c);
				if (cpu_c < rdata.min_cpu || !rdata.measured) upd.min_cpu = cpu_c;
				if (cpu_c > rdata.max_cpu) upd.max_cpu = cpu_c;
				if (el_c < rdata.min_elapsed || !rdata.measured) upd.min_elapsed = el_c;
				if (el_c > rdata.max_elapsed) upd.max_elapsed = el_c;
				upd.measured = 1'b1;
				upd.paused_total = '0;
			end
			CMD_PAUSE: begin
				upd.pause_start_tick = now_q;
				upd.is_paused = 1'b1;
			end
			CMD_RESUME: begin
				upd.is_paused = 1'b0;
				upd.paused_total = (rdata.paused_total + t_c) & TMASK;
			end
			CMD_CLR_CUM:   upd.cumulative_cpu = '0;
			CMD_CLR_COUNT: upd.stop_count = '0;
			default: ;
		endcase
	end

	// Memory port selection
	always_comb begin
		raddr = chan_q[AW-1:0];
		waddr = chan_q[AW-1:0];
		wdata = upd;
		we    = 1'b0;
		if (state_q == ST_IDLE) begin
			raddr = channel[AW-1:0];
		end else if (state_q == ST_READ) begin
			we = !oor_q;
		end else if (state_q == ST_WRITE) begin
			raddr = own_q.preempter_index[AW-1:0];
		end else if (state_q == ST_PREEMPT) begin
			waddr = own_q.preempter_index[AW-1:0];
			wdata = rdata;
			wdata.preempted_total = (rdata.preempted_total + el_q) & TMASK;
			we = !pre_hit_q;
		end
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_idx_q <= '0;
			cur_vld_q <= 1'b0;
			paused_q  <= '0;
			done      <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= 1'b0;
			if (state_q == ST_READ) begin
				if (oor_q) begin
					done <= 1'b1;
				end else begin
					paused_q[chan_q[AW-1:0]] <= upd.is_paused;
					if (kind_q == CMD_START) begin
						cur_idx_q <= chan_q;
						cur_vld_q <= 1'b1;
					end else if (kind_q == CMD_STOP) begin
						cur_idx_q <= rdata.preempter_index;
						cur_vld_q <= rdata.preempter_valid;
					end
					if (!(kind_q == CMD_STOP && rdata.preempter_valid
						&& 32'(rdata.preempter_index) < CHANNELS))
						done <= 1'b1;
				end
			end else if (state_q == ST_PREEMPT) begin
				done <= 1'b1;
			end
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			kind_q <= kind;
			chan_q <= channel;
			now_q  <= now_ticks & TMASK;
			oor_q  <= (32'(channel) >= CHANNELS);
		end
		if (state_q == ST_READ) begin
			// hold the entry as read: its preempter fields steer the second pass
			own_q     <= rdata;
			el_q      <= el_c;
			pre_hit_q <= (rdata.preempter_index == chan_q);
			elapsed_time        <= oor_q ? '0 : upd.last_elapsed;
			cpu_time            <= oor_q ? '0 : upd.last_cpu;
			min_cpu_time        <= oor_q ? '0 : upd.min_cpu;
			max_cpu_time        <= oor_q ? '0 : upd.max_cpu;
			min_elapsed_time    <= oor_q ? '0 : upd.min_elapsed;
			max_elapsed_time    <= oor_q ? '0 : upd.max_elapsed;
			preempted_time      <= oor_q ? '0 : upd.preempted_total;
			cumulative_cpu_time <= oor_q ? '0 : upd.cumulative_cpu;
			event_count         <= oor_q ? '0 : upd.stop_count;
			total_event_count   <= oor_q ? '0 : upd.total_stops;
			period_time         <= oor_q ? '0 : upd.last_period;
			measured_once       <= oor_q ? 1'b0 : upd.measured;
		end
	end
endmodule

### test/psp_checker.sv
`timescale 1ns / 1ps
// Checker for the preemptive stopwatch profiler: watches requests and result strobes,
// keeps its own copy of the channel bank and compares each result field by field.
// Depends on psp_pkg.
module psp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  kind,
	input  logic [2:0]  channel,
	input  logic [31:0] now_ticks,
	input  logic        done,
	input  logic [31:0] elapsed_time,
	input  logic [31:0] cpu_time,
	input  logic [31:0] min_cpu_time,
	input  logic [31:0] max_cpu_time,
	input  logic [31:0] min_elapsed_time,
	input  logic [31:0] max_elapsed_time,
	input  logic [31:0] preempted_time,
	input  logic [47:0] cumulative_cpu_time,
	input  logic [31:0] event_count,
	input  logic [47:0] total_event_count,
	input  logic [31:0] period_time,
	input  logic        measured_once,
	output int          fail_count,
	output int          pending_count,
	output int          result_count
);
	import psp_pkg::*;

	typedef struct packed {
		logic [31:0] elapsed;
		logic [31:0] cpu;
		logic [31:0] min_cpu;
		logic [31:0] max_cpu;
		logic [31:0] min_el;
		logic [31:0] max_el;
		logic [31:0] preempted;
		logic [47:0] cum_cpu;
		logic [31:0] count;
		logic [47:0] total;
		logic [31:0] period;
		logic        measured;
	} stats_t;

	entry_t     bank [8];
	logic [2:0] running_ch;
	logic       running_valid;
	stats_t     stats_queue [$];

	// Apply one request to the shadow bank and return the channel's statistics
	function automatic stats_t apply_request(logic [2:0] k, logic [2:0] c, logic [31:0] now);
		stats_t r;
		logic [31:0] el;
		logic [31:0] cpu;
		logic [31:0] prev;
		case (k)
			CMD_START: begin
				prev = bank[c].start_tick;
				bank[c].start_tick = now;
				if (running_valid && !bank[running_ch].is_paused) begin
					bank[c].preempter_index = running_ch;
					bank[c].preempter_valid = 1'b1;
				end
				running_ch = c;
				running_valid = 1'b1;
				bank[c].preempted_total = '0;
				if (bank[c].measured)
					bank[c].last_period = now - prev;
			end
			CMD_STOP: begin
				el = now - bank[c].start_tick - bank[c].paused_total;
				bank[c].last_elapsed = el;
				if (bank[c].preempter_valid)
					bank[bank[c].preempter_index].preempted_total =
						bank[bank[c].preempter_index].preempted_total + el;
				running_ch = bank[c].preempter_index;
				running_valid = bank[c].preempter_valid;
				bank[c].preempter_index = '0;
				bank[c].preempter_valid = 1'b0;
				bank[c].stop_count++;
				bank[c].total_stops++;
				cpu = el - bank[c].preempted_total;
				bank[c].last_cpu = cpu;
				bank[c].cumulative_cpu = bank[c].cumulative_cpu + cpu;
				if (cpu < bank[c].min_cpu) bank[c].min_cpu = cpu;
				if (cpu > bank[c].max_cpu) bank[c].max_cpu = cpu;
				if (el < bank[c].min_elapsed) bank[c].min_elapsed = el;
				if (el > bank[c].max_elapsed) bank[c].max_elapsed = el;
				if (!bank[c].measured) begin
					bank[c].min_cpu = cpu;
					bank[c].min_elapsed = el;
					bank[c].measured = 1'b1;
				end
				bank[c].paused_total = '0;
			end
			CMD_PAUSE: begin
				bank[c].pause_start_tick = now;
				bank[c].is_paused = 1'b1;
			end
			CMD_RESUME: begin
				bank[c].is_paused = 1'b0;
				bank[c].paused_total = bank[c].paused_total + (now - bank[c].pause_start_tick);
			end
			CMD_CLR_CUM: bank[c].cumulative_cpu = '0;
			CMD_CLR_COUNT: bank[c].stop_count = '0;
			default: ;
		endcase
		r.elapsed   = bank[c].last_elapsed;
		r.cpu       = bank[c].last_cpu;
		r.min_cpu   = bank[c].min_cpu;
		r.max_cpu   = bank[c].max_cpu;
		r.min_el    = bank[c].min_elapsed;
		r.max_el    = bank[c].max_elapsed;
		r.preempted = bank[c].preempted_total;
		r.cum_cpu   = bank[c].cumulative_cpu;
		r.count     = bank[c].stop_count;
		r.total     = bank[c].total_stops;
		r.period    = bank[c].last_period;
		r.measured  = bank[c].measured;
		return r;
	endfunction

	// Predict on each accepted request, compare on each strobe
	always @(posedge clk or negedge arst_n) begin
		stats_t got;
		stats_t want;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				bank[i] = '0;
			end
			running_ch = '0;
			running_valid = 1'b0;
			stats_queue.delete();
			fail_count <= 0;
			pending_count <= 0;
			result_count <= 0;
		end else begin
			if (done) begin
				got = {elapsed_time, cpu_time, min_cpu_time, max_cpu_time, min_elapsed_time,
					max_elapsed_time, preempted_time, cumulative_cpu_time, event_count,
					total_event_count, period_time, measured_once};
				result_count <= result_count + 1;
				if (stats_queue.size() == 0) begin
					$display("%0t: result with no request waiting: %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = stats_queue.pop_front();
					if (got !== want) begin
						$display("%0t: result mismatch", $time);
						$display("  expected %h", want);
						$display("  actual   %h", got);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				stats_queue.push_back(apply_request(kind, channel, now_ticks));
			pending_count <= stats_queue.size();
		end
	end
endmodule

### test/preemptive_stopwatch_profiler_unit_tb.sv
`timescale 1ns / 1ps
// Top of the stopwatch profiler testbench: clock, reset, directed and random requests,
// watchdog and verdict. Depends on psp_pkg, the profiler unit and psp_checker.
module preemptive_stopwatch_profiler_unit_tb;
	import psp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  kind;
	logic [2:0]  channel;
	logic [31:0] now_ticks;
	logic        done;
	logic [31:0] elapsed_time, cpu_time, min_cpu_time, max_cpu_time;
	logic [31:0] min_elapsed_time, max_elapsed_time, preempted_time;
	logic [47:0] cumulative_cpu_time, total_event_count;
	logic [31:0] event_count, period_time;
	logic        measured_once;
	int          fail_count, pending_count, result_count;
	int          idle_cycles;
	int          request_count;
	logic [31:0] tick;

	preemptive_stopwatch_profiler_unit dut (.*);
	psp_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Count cycles with no accepted request or result
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("watchdog expired with %0d results pending", pending_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Issue one request, with a random gap ahead of it
	task automatic issue(cmd_t k, logic [2:0] c, logic [31:0] now);
		int gap;
		gap = (request_count % 50 < 10) ? 0 : $urandom_range(0, 19);
		// Drop the request line only when a gap follows
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		channel <= c;
		now_ticks <= now;
		do @(posedge clk); while (busy);
		request_count++;
	endtask

	// Advance the tick clock by a small or occasionally huge step
	function automatic logic [31:0] step_tick();
		tick = tick + (($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 300));
		return tick;
	endfunction

	initial begin
		logic [2:0] stack [$];
		logic [2:0] c;
		int pick;
		idle_cycles = 0;
		request_count = 0;
		tick = '0;
		arst_n = 1'b0;
		start = 1'b0;
		kind = CMD_READ;
		channel = '0;
		now_ticks = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reads at reset, nested preemption, pause/resume, wraps, clears
		issue(CMD_READ, 3'd7, 32'hFFFF_FFFF);
		issue(CMD_STOP, 3'd5, 32'h0000_0010);
		issue(CMD_START, 3'd0, 32'hFFFF_FFF0);
		issue(CMD_START, 3'd1, 32'h0000_0005);
		issue(CMD_PAUSE, 3'd1, 32'h0000_0008);
		issue(CMD_PAUSE, 3'd1, 32'h0000_000A);
		issue(CMD_START, 3'd2, 32'h0000_000C);
		issue(CMD_RESUME, 3'd1, 32'h0000_0020);
		issue(CMD_RESUME, 3'd1, 32'h0000_0030);
		issue(CMD_STOP, 3'd2, 32'h0000_0040);
		issue(CMD_STOP, 3'd1, 32'h0000_0050);
		issue(CMD_START, 3'd0, 32'h0000_0060);
		issue(CMD_STOP, 3'd0, 32'h0000_0070);
		issue(CMD_START, 3'd0, 32'h8000_0000);
		issue(CMD_STOP, 3'd0, 32'h7FFF_FFFF);
		issue(CMD_START, 3'd0, 32'h7FFF_FFFF);
		issue(CMD_STOP, 3'd0, 32'h7FFF_FFFF);
		issue(CMD_CLR_CUM, 3'd0, 32'd0);
		issue(CMD_CLR_COUNT, 3'd0, 32'd0);
		issue(cmd_t'(3'd7), 3'd0, 32'd1);
		issue(CMD_READ, 3'd1, 32'd2);

		// Random: mostly nested start/stop with pause pairs, some noise
		repeat (680) begin
			pick = $urandom_range(0, 99);
			if (pick < 35 && stack.size() < 8) begin
				c = 3'($urandom_range(0, 7));
				issue(CMD_START, c, step_tick());
				stack.push_back(c);
			end else if (pick < 65 && stack.size() > 0) begin
				issue(CMD_STOP, stack.pop_back(), step_tick());
			end else if (pick < 75 && stack.size() > 0) begin
				c = stack[stack.size() - 1];
				issue(CMD_PAUSE, c, step_tick());
				issue(CMD_RESUME, c, step_tick());
			end else if (pick < 88) begin
				issue(cmd_t'(3'($urandom_range(2, 7))), 3'($urandom_range(0, 7)), $urandom());
			end else if (pick < 93) begin
				issue(CMD_STOP, 3'($urandom_range(0, 7)), $urandom());
			end else begin
				issue(CMD_READ, 3'($urandom_range(0, 7)), step_tick());
			end
		end
		start <= 1'b0;

		// Drain, then let the last strobe settle
		while (pending_count != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("%0d requests issued, %0d results checked across nested channel runs",
			request_count, result_count);
		if (fail_count == 0 && pending_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
